// File: rtl/fxmd_pkg.sv
// Shared types, constants and helpers for the fixed-point multiply/divide unit.
package fxmd_pkg;

   localparam int unsigned DATA_W     = 32;
   // quotient bits that survive the overflow guard
   localparam int unsigned QUO_BITS   = 30;
   // pipeline depth from the operand ports to the aligned result ahead of the output register
   localparam int unsigned PIPE_DEPTH = QUO_BITS + 1;
   localparam int unsigned MUL_STAGES = 4;
   localparam int unsigned MUL_PAD    = PIPE_DEPTH - MUL_STAGES;

   localparam logic OP_MUL = 1'b0;
   localparam logic OP_DIV = 1'b1;

   typedef logic [DATA_W-1:0]   word_type;
   typedef logic [QUO_BITS-1:0] quo_type;

   localparam word_type MOST_POS = 32'h7FFF_FFFF;
   localparam word_type MOST_NEG = 32'h8000_0000;

   typedef struct packed {
      logic differ;
      logic sat;
   } div_flags_type;

   // true unsigned magnitude: the most negative value maps to 2^31
   function automatic word_type magnitude(input word_type v);
      magnitude = v[DATA_W-1] ? (~v + word_type'(1)) : v;
   endfunction

endpackage

// File: rtl/fxmd_mul.sv
// Pipelined signed fixed-point multiplier with a delay line to match the divider.
module fxmd_mul #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic              clock,
   input  fxmd_pkg::word_type op_a,
   input  fxmd_pkg::word_type op_b,
   output fxmd_pkg::word_type product
);
   import fxmd_pkg::*;

   localparam int unsigned PROD_W = 2 * DATA_W;

   word_type          ma_ff, mb_ff;
   logic              neg1_ff, neg2_ff, neg3_ff;
   logic [31:0]       pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [PROD_W-1:0] sum_ff, sum_in;
   logic [PROD_W-1:0] signed_prod;
   word_type          res_ff, res_in;
   word_type          pad_ff [0:MUL_PAD-1];

   // magnitudes and product sign
   always_ff @(posedge clock) begin
      ma_ff   <= magnitude(op_a);
      mb_ff   <= magnitude(op_b);
      neg1_ff <= op_a[DATA_W-1] ^ op_b[DATA_W-1];
   end

   // four 16x16 partial products
   always_ff @(posedge clock) begin
      pp_ll_ff <= {16'b0, ma_ff[15:0]}  * {16'b0, mb_ff[15:0]};
      pp_lh_ff <= {16'b0, ma_ff[15:0]}  * {16'b0, mb_ff[31:16]};
      pp_hl_ff <= {16'b0, ma_ff[31:16]} * {16'b0, mb_ff[15:0]};
      pp_hh_ff <= {16'b0, ma_ff[31:16]} * {16'b0, mb_ff[31:16]};
      neg2_ff  <= neg1_ff;
   end

   assign sum_in = {pp_hh_ff, 32'b0}
                 + {16'b0, pp_lh_ff, 16'b0}
                 + {16'b0, pp_hl_ff, 16'b0}
                 + {32'b0, pp_ll_ff};

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      neg3_ff <= neg2_ff;
   end

   // restore the sign, then an arithmetic shift is a plain part-select
   assign signed_prod = neg3_ff ? (~sum_ff + PROD_W'(1)) : sum_ff;
   assign res_in      = signed_prod[FRAC_BITS+DATA_W-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      pad_ff[0] <= res_ff;
      for (int i = 1; i < MUL_PAD; i++) begin
         pad_ff[i] <= pad_ff[i-1];
      end
   end

   assign product = pad_ff[MUL_PAD-1];

endmodule

// File: rtl/fxmd_div.sv
// Pipelined restoring divider with overflow guard, one quotient bit per stage.
module fxmd_div #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                   clock,
   input  fxmd_pkg::word_type      dividend,
   input  fxmd_pkg::word_type      divisor,
   output fxmd_pkg::quo_type       quotient,
   output fxmd_pkg::div_flags_type flags
);
   import fxmd_pkg::*;

   localparam int unsigned GUARD_SHIFT = QUO_BITS - FRAC_BITS;
   localparam int unsigned NUM_W       = DATA_W + FRAC_BITS;

   word_type          ma_in, mb_in;
   logic [NUM_W-1:0]  full_in;
   div_flags_type     flags_in;

   word_type          rem_ff [0:QUO_BITS-1];
   quo_type           num_ff [0:QUO_BITS-1];
   word_type          dvs_ff [0:QUO_BITS-1];
   quo_type           quo_ff [0:QUO_BITS];
   div_flags_type     flg_ff [0:QUO_BITS];

   // prep: magnitudes, guard, and the top of the shifted dividend as first remainder
   assign ma_in           = magnitude(dividend);
   assign mb_in           = magnitude(divisor);
   assign full_in         = {ma_in, {FRAC_BITS{1'b0}}};
   assign flags_in.differ = dividend[DATA_W-1] ^ divisor[DATA_W-1];
   assign flags_in.sat    = (mb_in == '0) || ((ma_in >> GUARD_SHIFT) >= mb_in);

   always_ff @(posedge clock) begin
      rem_ff[0] <= ma_in >> GUARD_SHIFT;
      num_ff[0] <= full_in[QUO_BITS-1:0];
      dvs_ff[0] <= mb_in;
      quo_ff[0] <= '0;
      flg_ff[0] <= flags_in;
   end

   for (genvar k = 1; k <= QUO_BITS; k++) begin : g_stage
      logic [DATA_W:0] trial;
      logic [DATA_W:0] diff;
      logic            ge;

      assign trial = {rem_ff[k-1], num_ff[k-1][QUO_BITS-1]};
      assign ge    = trial >= {1'b0, dvs_ff[k-1]};
      assign diff  = trial - {1'b0, dvs_ff[k-1]};

      always_ff @(posedge clock) begin
         quo_ff[k] <= {quo_ff[k-1][QUO_BITS-2:0], ge};
         flg_ff[k] <= flg_ff[k-1];
      end

      if (k < QUO_BITS) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[k] <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            num_ff[k] <= {num_ff[k-1][QUO_BITS-2:0], 1'b0};
            dvs_ff[k] <= dvs_ff[k-1];
         end
      end
   end

   assign quotient = quo_ff[QUO_BITS];
   assign flags    = flg_ff[QUO_BITS];

endmodule

// File: rtl/fixed_point_mul_div_unit.sv
// Top level of the signed fixed-point multiply/divide unit.
//
//   channel   ports                                          handshake
//   request   req_type, req_operand_a, req_operand_b         start high, busy low
//   response  rsp_result_value, rsp_saturated                rsp_valid, one cycle
//
// A word enters on any cycle; busy never rises, so a new word may follow every cycle.
// Each word passes from acceptance to its response through one prep stage, one
// stage for each of the 30 quotient bits, and the output register.
// Multiplies run a four-stage multiplier padded to the same depth, so order holds.
// Reset clears the valid line, the output strobe and the saturated flag only; payload is not reset.
// The receiver cannot stall; nothing in the pipe ever waits.
module fixed_point_mul_div_unit #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_type,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_result_value,
   output logic               rsp_saturated
);
   import fxmd_pkg::*;

   logic                  accept;
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic [PIPE_DEPTH-1:0] op_ff;
   word_type              mul_res;
   quo_type               div_quo;
   div_flags_type         div_flags;
   word_type              quo_ext;
   word_type              res_in, res_ff;
   logic                  sat_in, sat_ff;
   logic                  valid_ff;

   // the pipe never holds off a word
   assign busy   = 1'b0;
   assign accept = start && !busy;

   fxmd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock   (clock),
      .op_a    (word_type'(req_operand_a)),
      .op_b    (word_type'(req_operand_b)),
      .product (mul_res)
   );

   fxmd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .dividend (word_type'(req_operand_a)),
      .divisor  (word_type'(req_operand_b)),
      .quotient (div_quo),
      .flags    (div_flags)
   );

   // advance valid and operation alongside the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= {op_ff[PIPE_DEPTH-2:0], req_type};
   end

   // for divides apply the sign to the quotient or pick the saturation value; multiplies pass the product
   assign quo_ext = {{(DATA_W-QUO_BITS){1'b0}}, div_quo};

   always_comb begin
      if (op_ff[PIPE_DEPTH-1] == OP_DIV) begin
         if (div_flags.sat) begin
            res_in = div_flags.differ ? MOST_NEG : MOST_POS;
         end else begin
            res_in = div_flags.differ ? (~quo_ext + word_type'(1)) : quo_ext;
         end
      end else begin
         res_in = mul_res;
      end
   end

   // flag only real divide words, so an empty slot never raises it
   assign sat_in = vld_ff[PIPE_DEPTH-1] && (op_ff[PIPE_DEPTH-1] == OP_DIV) && div_flags.sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sat_ff   <= 1'b0;
      end else begin
         valid_ff <= vld_ff[PIPE_DEPTH-1];
         sat_ff   <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_saturated    = sat_ff;
   assign rsp_result_value = $signed(res_ff);

   a_fixed_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(PIPE_DEPTH + 1) rsp_valid)
      else $error("response missing at fixed latency");

   a_strobe_from_pipe : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(vld_ff[PIPE_DEPTH-1]))
      else $error("response strobe without a word in the pipe");

   a_sat_only_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_saturated |-> rsp_valid)
      else $error("saturated raised without a response");

   a_sat_value : assert property (@(posedge clock) disable iff (reset)
      rsp_saturated |-> ($unsigned(rsp_result_value) == MOST_NEG ||
                         $unsigned(rsp_result_value) == MOST_POS))
      else $error("saturated response is not a limit value");

   a_quiet_after_reset : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response strobe straight after reset");

endmodule

// File: test/tb_fixed_point_mul_div_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the signed 16.16 fixed-point multiply/divide unit.
module tb_fixed_point_mul_div_unit;
   import fxmd_pkg::*;

   localparam int unsigned FRAC_BITS   = 16;
   // guard on magnitudes: a divide saturates when |a| >> GUARD_SHIFT >= |b|
   localparam int unsigned GUARD_SHIFT = 30 - FRAC_BITS;
   localparam int unsigned RANDOM_WORDS = 1950;
   // wait for a stray response: the depth of the pipe with a margin on top
   localparam int unsigned DRAIN_CYCLES = 48;
   // worst case is roughly 2000 words plus the longest gaps between bursts, so this is ample
   localparam int unsigned CYCLE_LIMIT  = 500000;

   typedef struct packed {
      word_type value;
      logic     sat;
   } fx_result_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_type;
   logic signed [31:0] req_operand_a;
   logic signed [31:0] req_operand_b;
   logic               rsp_valid;
   logic signed [31:0] rsp_result_value;
   logic               rsp_saturated;

   fx_result_type pending_results[$];
   int unsigned   mismatch_count = 0;
   int unsigned   cycle_count    = 0;

   fixed_point_mul_div_unit #(
      .FRAC_BITS(FRAC_BITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_operand_a   (req_operand_a),
      .req_operand_b   (req_operand_b),
      .rsp_valid       (rsp_valid),
      .rsp_result_value(rsp_result_value),
      .rsp_saturated   (rsp_saturated)
   );

   always #2 clock = ~clock;

   // Work out the product or quotient of one word, bit for bit.
   function automatic fx_result_type compute_fx_result(input logic op, input word_type a,
                                                       input word_type b);
      fx_result_type res;
      longint        product;
      logic [32:0]   mag_a;
      logic [32:0]   mag_b;
      logic [63:0]   quotient;
      res.sat = 1'b0;
      if (op == OP_MUL) begin
         // full signed product, arithmetic shift, keep the low word (wraps on overflow)
         product   = longint'($signed(a)) * longint'($signed(b));
         res.value = word_type'(product >>> FRAC_BITS);
      end else begin
         // true magnitudes: the most negative value becomes 2^31, no wrap
         mag_a = a[31] ? (33'h1_0000_0000 - {1'b0, a}) : {1'b0, a};
         mag_b = b[31] ? (33'h1_0000_0000 - {1'b0, b}) : {1'b0, b};
         if (mag_b == 33'd0 || (mag_a >> GUARD_SHIFT) >= mag_b) begin
            res.sat   = 1'b1;
            res.value = (a[31] ^ b[31]) ? MOST_NEG : MOST_POS;
         end else begin
            // truncate toward zero: divide magnitudes, then apply the sign
            quotient = ({31'd0, mag_a} << FRAC_BITS) / {31'd0, mag_b};
            if (a[31] ^ b[31]) begin
               quotient = -quotient;
            end
            res.value = quotient[31:0];
         end
      end
      return res;
   endfunction

   // Pick an operand: full range, a random bit width with random sign, or a corner value.
   function automatic word_type rand_operand();
      word_type    v;
      int unsigned width;
      case ($urandom_range(0, 4))
         0, 1: begin
            v = $urandom();
         end
         2, 3: begin
            width = $urandom_range(1, 31);
            v = $urandom() & ((32'h1 << width) - 32'h1);
            if ($urandom_range(0, 1) == 1) begin
               v = -v;
            end
         end
         default: begin
            case ($urandom_range(0, 7))
               0:       v = 32'h0000_0000;
               1:       v = 32'h0000_0001;
               2:       v = 32'hFFFF_FFFF;
               3:       v = MOST_POS;
               4:       v = MOST_NEG;
               5:       v = 32'h0001_0000;
               6:       v = 32'hFFFF_0000;
               default: v = 32'h0000_8000;
            endcase
         end
      endcase
      return v;
   endfunction

   // Present one word from the falling edge and hold it until the unit takes it.
   task automatic send_word(input logic op, input word_type a, input word_type b);
      @(negedge clock);
      start         = 1'b1;
      req_type      = op;
      req_operand_a = a;
      req_operand_b = b;
      do begin
         @(posedge clock);
      end while (busy);
      pending_results.push_back(compute_fx_result(op, a, b));
   endtask

   // Drop start for a number of cycles.
   task automatic hold_off(input int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   // Extremes of the multiply: sign combinations, unit values and wrap.
   task automatic test_multiply_corners();
      send_word(OP_MUL, MOST_POS, MOST_POS);
      send_word(OP_MUL, MOST_NEG, MOST_NEG);
      send_word(OP_MUL, MOST_NEG, MOST_POS);
      send_word(OP_MUL, 32'hFFFF_FFFF, 32'h0000_0001);
      send_word(OP_MUL, 32'h0001_0000, 32'h0001_0000);
      send_word(OP_MUL, 32'h0001_8000, 32'hFFFE_0000);
      send_word(OP_MUL, 32'h0100_0000, 32'h0100_0000);
      send_word(OP_MUL, 32'h0000_0000, MOST_NEG);
      hold_off(1);
   endtask

   // Divide corners: zero divisor by dividend sign, the most negative operand,
   // both sides of the overflow guard and truncation toward zero.
   task automatic test_divide_corners();
      send_word(OP_DIV, 32'h0003_0000, 32'h0000_0000);
      send_word(OP_DIV, 32'hFFFD_0000, 32'h0000_0000);
      send_word(OP_DIV, 32'h0000_0000, 32'h0000_0000);
      send_word(OP_DIV, MOST_NEG, 32'h0000_0001);
      send_word(OP_DIV, MOST_NEG, 32'hFFFF_FFFF);
      send_word(OP_DIV, MOST_NEG, MOST_NEG);
      send_word(OP_DIV, MOST_NEG, 32'h0002_0000);
      send_word(OP_DIV, MOST_NEG, 32'h0002_0001);
      send_word(OP_DIV, 32'h3FFF_FFFF, 32'h0001_0000);
      send_word(OP_DIV, 32'h4000_0000, 32'h0001_0000);
      send_word(OP_DIV, 32'h0007_0000, 32'hFFFE_0000);
      send_word(OP_DIV, 32'hFFFF_FFFF, 32'h0003_0000);
      send_word(OP_DIV, MOST_POS, MOST_NEG);
      hold_off(1);
   endtask

   // Random traffic in bursts. A quarter of divides sit just either side of
   // the overflow guard so that both outcomes turn up often.
   task automatic test_random_traffic();
      int unsigned words_left;
      int unsigned burst_len;
      int unsigned mag_b;
      int unsigned mag_a;
      logic        op;
      word_type    a;
      word_type    b;
      words_left = RANDOM_WORDS;
      while (words_left > 0) begin
         burst_len = $urandom_range(1, 40);
         while (burst_len > 0 && words_left > 0) begin
            op = logic'($urandom_range(0, 1));
            if (op == OP_DIV && $urandom_range(0, 3) == 0) begin
               mag_b = $urandom_range(1, 32'h1_FFFF);
               mag_a = (mag_b << GUARD_SHIFT) + $urandom_range(0, 4) - 2;
               a = ($urandom_range(0, 1) == 1) ? -word_type'(mag_a) : word_type'(mag_a);
               b = ($urandom_range(0, 1) == 1) ? -word_type'(mag_b) : word_type'(mag_b);
            end else begin
               a = rand_operand();
               b = rand_operand();
            end
            send_word(op, a, b);
            burst_len--;
            words_left--;
         end
         // mostly short gaps, some long enough to span the pipe, some none at all
         case ($urandom_range(0, 4))
            0:       hold_off(0);
            1:       hold_off($urandom_range(10, 40));
            default: hold_off($urandom_range(1, 5));
         endcase
      end
      hold_off(1);
   endtask

   // Check each response against the oldest outstanding prediction.
   always @(posedge clock) begin
      fx_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: response with none outstanding, expected nothing, actual %h/%b",
                     $time, rsp_result_value, rsp_saturated);
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_value !== want.value) begin
               mismatch_count++;
               $display("%0t: result_value mismatch, expected %h, actual %h",
                        $time, want.value, rsp_result_value);
            end
            if (rsp_saturated !== want.sat) begin
               mismatch_count++;
               $display("%0t: saturated mismatch, expected %b, actual %b",
                        $time, want.sat, rsp_saturated);
            end
         end
      end
   end

   // Guard against a hang: end the run if it goes on far too long.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      // initialise every input before the first edge and hold reset
      reset         = 1'b1;
      start         = 1'b0;
      req_type      = OP_MUL;
      req_operand_a = '0;
      req_operand_b = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_multiply_corners();
      test_divide_corners();
      test_random_traffic();

      // drain the pipe, then wait out its latency for any stray response
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/fxmd_pkg.sv
rtl/fxmd_mul.sv
rtl/fxmd_div.sv
rtl/fixed_point_mul_div_unit.sv
test/tb_fixed_point_mul_div_unit.sv
